// ===== hdl/tsf_pkg.sv =====
// Package for the triangular smoothing filter.
// Holds the shared widths, reset values and parameter defaults.
// Has no dependencies.
package tsf_pkg;

  // Defaults for the top-level parameters.
  localparam int unsigned MAX_WIDTH_DEF   = 32;
  localparam int unsigned SAMPLE_BITS_DEF = 16;

  // Width register.
  localparam int unsigned          CFG_W     = 6;
  localparam logic [CFG_W-1:0]     CFG_RESET = CFG_W'(3);

  // Result word: signed Q.8.
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned FRAC_BITS = 8;

  // Position counter within a record, saturating.
  localparam int unsigned CNT_W = 7;

endpackage

// ===== hdl/tsf_div.sv =====
// Bit-serial divider for the triangular smoothing filter.
// Rounds sum * 256 / (w * w) half away from zero and saturates to Q.8.
// Depends on tsf_pkg.
module tsf_div #(
  parameter int unsigned SUM_W = 26,
  parameter int unsigned WID_W = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [SUM_W-1:0]         sum_i,
  input  logic        [WID_W-1:0]         width_i,
  output logic                            done_o,
  output logic signed [tsf_pkg::OUT_W-1:0] result_o
);

  localparam int unsigned NUM_W = SUM_W + tsf_pkg::FRAC_BITS + 1;
  localparam int unsigned SQ_W  = 2 * WID_W;
  localparam int unsigned DEN_W = SQ_W + 1;
  localparam int unsigned REM_W = DEN_W + 1;
  localparam int unsigned CNT_W = $clog2(NUM_W + 1);
  localparam int unsigned CMP_W = (NUM_W > tsf_pkg::OUT_W) ? NUM_W : tsf_pkg::OUT_W;
  localparam logic [CMP_W-1:0] POS_LIM = CMP_W'((2 ** (tsf_pkg::OUT_W - 1)) - 1);
  localparam logic [CMP_W-1:0] NEG_LIM = CMP_W'(2 ** (tsf_pkg::OUT_W - 1));

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0] num_q, num_d;
  logic [DEN_W-1:0] den_q, den_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic             neg_q, neg_d;

  logic [SUM_W-1:0] mag;
  logic [SQ_W-1:0]  sq;
  logic [REM_W-1:0] shifted;
  logic [REM_W-1:0] diff;
  logic             fits;
  logic [CMP_W-1:0] q_ext;
  logic [CMP_W-1:0] q_neg;

  always_comb begin
    mag     = sum_i[SUM_W-1] ? (~$unsigned(sum_i) + SUM_W'(1)) : $unsigned(sum_i);
    sq      = SQ_W'(width_i) * SQ_W'(width_i);
    shifted = {rem_q, num_q[NUM_W-1]};
    diff    = shifted - {1'b0, den_q};
    fits    = (shifted >= {1'b0, den_q});

    busy_d = busy_q;
    cnt_d  = cnt_q;
    num_d  = num_q;
    den_d  = den_q;
    rem_d  = rem_q;
    neg_d  = neg_q;

    if (start_i) begin
      // Numerator 2*|sum|*256 + w*w over denominator 2*w*w gives round half up.
      busy_d = 1'b1;
      cnt_d  = CNT_W'(NUM_W);
      num_d  = {mag, (tsf_pkg::FRAC_BITS + 1)'(0)} + NUM_W'(sq);
      den_d  = {sq, 1'b0};
      rem_d  = '0;
      neg_d  = sum_i[SUM_W-1];
    end else if (busy_q) begin
      // One quotient bit per cycle; it enters at the bottom of the numerator.
      num_d = {num_q[NUM_W-2:0], fits};
      rem_d = fits ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign done_o = !busy_q;

  always_comb begin
    q_ext = CMP_W'(num_q);
    q_neg = ~q_ext + CMP_W'(1);
    if (neg_q) begin
      if (q_ext > NEG_LIM) begin
        result_o = NEG_LIM[tsf_pkg::OUT_W-1:0];
      end else begin
        result_o = q_neg[tsf_pkg::OUT_W-1:0];
      end
    end else begin
      if (q_ext > POS_LIM) begin
        result_o = POS_LIM[tsf_pkg::OUT_W-1:0];
      end else begin
        result_o = q_ext[tsf_pkg::OUT_W-1:0];
      end
    end
  end

endmodule

// ===== hdl/triangular_smoothing_filter_top.sv =====
// Triangular smoothing filter top level; uses tsf_pkg and the divider in tsf_div.
// A word that yields a result has it valid once the sums, the divide and the output register
// are through; the next word is taken only after that result has been handed to the output
// register, or right after the step that follows the sums when no result is due. The final
// word adds up to (w - 1)/2 passes of the sums, each with a divide where a result is due, then the zero words.
// Reset is asynchronous, active low: width back to 3, delay lines empty by their fill counts.
module triangular_smoothing_filter_top #(
  parameter int unsigned MAX_WIDTH   = tsf_pkg::MAX_WIDTH_DEF,
  parameter int unsigned SAMPLE_BITS = tsf_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Width register.
  input  logic                             cfg_we_i,
  input  logic [tsf_pkg::CFG_W-1:0]        cfg_wdata_i,
  // Sample words in.
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]    sample_i,
  input  logic                             last_in_i,
  // Smoothed words out.
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [tsf_pkg::OUT_W-1:0] smoothed_o,
  output logic                             last_out_o
);

  localparam int unsigned PTR_W = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W = $clog2(MAX_WIDTH + 1);
  localparam int unsigned S1_W  = SAMPLE_BITS + PTR_W;
  localparam int unsigned S2_W  = S1_W + PTR_W;
  localparam int unsigned CNT_W = tsf_pkg::CNT_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;  // waiting for a sample word
  localparam logic [2:0] ST_SUM  = 3'd1;  // walking both delay lines, one entry a cycle
  localparam logic [2:0] ST_STEP = 3'd2;  // insert into the delay lines, decide on a result
  localparam logic [2:0] ST_DIV  = 3'd3;  // waiting for the divider
  localparam logic [2:0] ST_EMIT = 3'd4;  // hand the quotient to the output register
  localparam logic [2:0] ST_ZERO = 3'd5;  // zero tail of a record

  // Control registers.
  logic [2:0]                state_q, state_d;
  logic [tsf_pkg::CFG_W-1:0] width_q, width_d;
  logic                      last_q, last_d;
  logic [CNT_W-1:0]          pos_q, pos_d;
  logic [WID_W-1:0]          n2_q, n2_d;
  logic [PTR_W-1:0]          hd1_q, hd1_d;
  logic [PTR_W-1:0]          hd2_q, hd2_d;
  logic [WID_W-1:0]          rd_cnt_q, rd_cnt_d;
  logic                      pipe_v_q;
  logic [WID_W-1:0]          flush_q, flush_d;
  logic [CNT_W-1:0]          idx_q, idx_d;
  logic [WID_W-1:0]          zcnt_q, zcnt_d;
  logic                      out_valid_q, out_valid_d;

  // Payload registers.
  logic signed [SAMPLE_BITS-1:0]    x_q;
  logic [PTR_W-1:0]                 pipe_j_q;
  logic signed [SAMPLE_BITS-1:0]    rd1_q;
  logic signed [S1_W-1:0]           rd2_q;
  logic signed [S1_W-1:0]           acc1_q, acc1_d;
  logic signed [S2_W-1:0]           acc2_q, acc2_d;
  logic signed [tsf_pkg::OUT_W-1:0] smoothed_q, smoothed_d;
  logic                             last_out_q, last_out_d;

  // Delay lines as circular buffers; entry k after the head is k words old.
  logic signed [SAMPLE_BITS-1:0] sample_mem_q [MAX_WIDTH];
  logic signed [S1_W-1:0]        stage_mem_q  [MAX_WIDTH];

  // Effective width and the derived offsets.
  logic [WID_W-1:0] w_eff;
  logic [WID_W-1:0] half_w;
  logic [WID_W-1:0] d1;
  logic [WID_W-1:0] n_rd;

  // Delay line addressing.
  logic [PTR_W:0]   a1_sum, a2_sum;
  logic [PTR_W-1:0] rd_addr1, rd_addr2;
  logic [PTR_W-1:0] hd1_m1, hd2_m1;

  // Window sum walk.
  logic issue;
  logic sum_done;

  // Step decisions.
  logic [CNT_W-1:0]       i_val;
  logic [CNT_W-1:0]       cur_idx;
  logic [CNT_W-1:0]       o_val;
  logic                   s2_active;
  logic                   emit_now;
  logic signed [S1_W-1:0] sval;
  logic signed [S2_W-1:0] sum2;
  logic signed [S2_W-1:0] div_sum;
  logic                   div_start;
  logic                   div_done;
  logic signed [tsf_pkg::OUT_W-1:0] div_result;

  // Record end bookkeeping.
  logic [CNT_W:0] len;
  logic [CNT_W:0] d1_p1;
  logic [CNT_W:0] c1;

  logic mem1_we, mem2_we;
  logic slot_free;
  logic accept;

  // A width of zero acts as one; anything above the delay line depth saturates.
  always_comb begin
    if (width_q == '0) begin
      w_eff = WID_W'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_eff = WID_W'(MAX_WIDTH);
    end else begin
      w_eff = WID_W'(width_q);
    end
    half_w = w_eff >> 1;
    d1     = w_eff - WID_W'(1) - half_w;
    n_rd   = w_eff - WID_W'(1);
  end

  always_comb begin
    a1_sum   = {1'b0, hd1_q} + (PTR_W + 1)'(rd_cnt_q[PTR_W-1:0]);
    a2_sum   = {1'b0, hd2_q} + (PTR_W + 1)'(rd_cnt_q[PTR_W-1:0]);
    rd_addr1 = (a1_sum >= (PTR_W + 1)'(MAX_WIDTH)) ?
               PTR_W'(a1_sum - (PTR_W + 1)'(MAX_WIDTH)) : a1_sum[PTR_W-1:0];
    rd_addr2 = (a2_sum >= (PTR_W + 1)'(MAX_WIDTH)) ?
               PTR_W'(a2_sum - (PTR_W + 1)'(MAX_WIDTH)) : a2_sum[PTR_W-1:0];
    hd1_m1   = (hd1_q == '0) ? PTR_W'(MAX_WIDTH - 1) : hd1_q - PTR_W'(1);
    hd2_m1   = (hd2_q == '0) ? PTR_W'(MAX_WIDTH - 1) : hd2_q - PTR_W'(1);
  end

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_ready_o = (state_q == ST_IDLE);
  assign slot_free  = !out_valid_q || out_ready_i;

  // The walk reads the w - 1 words already in each line; each read comes back registered.
  assign issue    = (state_q == ST_SUM) && (rd_cnt_q < n_rd);
  assign sum_done = (state_q == ST_SUM) && !issue && !pipe_v_q;

  // Stage one runs for every sample word but the last of a record; stage two only once stage one has caught up,
  // and on every pass of the flush at the end of a record.
  always_comb begin
    i_val     = pos_q - CNT_W'(d1);
    s2_active = last_q || (pos_q >= CNT_W'(d1));
    if (!last_q && (i_val >= CNT_W'(half_w))) begin
      sval = acc1_q;
    end else begin
      sval = '0;
    end
    cur_idx  = last_q ? idx_q : i_val;
    o_val    = cur_idx - CNT_W'(d1);
    sum2     = acc2_q + S2_W'(sval);
    emit_now = s2_active && (cur_idx >= CNT_W'(d1));
    div_sum  = (o_val >= CNT_W'(half_w)) ? sum2 : '0;
  end

  assign div_start = (state_q == ST_STEP) && emit_now;
  assign mem1_we   = (state_q == ST_STEP) && !last_q;
  assign mem2_we   = (state_q == ST_STEP) && s2_active;

  // The final word of a record is not stored; it only drives the flush.
  always_comb begin
    len   = {1'b0, pos_q} + (CNT_W + 1)'(1);
    d1_p1 = (CNT_W + 1)'(d1) + (CNT_W + 1)'(1);
    c1    = (len < d1_p1) ? len : d1_p1;
  end

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    last_d      = last_q;
    pos_d       = pos_q;
    n2_d        = n2_q;
    hd1_d       = hd1_q;
    hd2_d       = hd2_q;
    rd_cnt_d    = '0;
    flush_d     = flush_q;
    idx_d       = idx_q;
    zcnt_d      = zcnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    acc1_d      = acc1_q;
    acc2_d      = '0;
    smoothed_d  = smoothed_q;
    last_out_d  = last_out_q;

    if (cfg_we_i) begin
      width_d = cfg_wdata_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        acc1_d = S1_W'(sample_i);
        if (accept) begin
          last_d = last_in_i;
          if (!last_in_i) begin
            state_d = ST_SUM;
          end else begin
            flush_d = WID_W'(c1 - (CNT_W + 1)'(1));
            idx_d   = CNT_W'(len - c1);
            zcnt_d  = WID_W'(c1);
            state_d = (c1 > (CNT_W + 1)'(1)) ? ST_SUM : ST_ZERO;
          end
        end
      end

      ST_SUM: begin
        acc2_d = acc2_q;
        if (issue) begin
          rd_cnt_d = rd_cnt_q + WID_W'(1);
        end else begin
          rd_cnt_d = rd_cnt_q;
        end
        // Entries older than the current record read as zero.
        if (pipe_v_q) begin
          if (CNT_W'(pipe_j_q) < pos_q) begin
            acc1_d = acc1_q + S1_W'(rd1_q);
          end
          if (WID_W'(pipe_j_q) < n2_q) begin
            acc2_d = acc2_q + S2_W'(rd2_q);
          end
        end
        if (sum_done) begin
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (!last_q) begin
          hd1_d = hd1_m1;
          pos_d = (pos_q == {CNT_W{1'b1}}) ? pos_q : pos_q + CNT_W'(1);
        end
        if (s2_active) begin
          hd2_d = hd2_m1;
          n2_d  = (n2_q == WID_W'(MAX_WIDTH)) ? n2_q : n2_q + WID_W'(1);
        end
        if (!last_q) begin
          state_d = emit_now ? ST_DIV : ST_IDLE;
        end else begin
          flush_d = flush_q - WID_W'(1);
          idx_d   = idx_q + CNT_W'(1);
          if (emit_now) begin
            state_d = ST_DIV;
          end else if (flush_q > WID_W'(1)) begin
            state_d = ST_SUM;
          end else begin
            state_d = ST_ZERO;
          end
        end
      end

      ST_DIV: begin
        if (div_done) begin
          state_d = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          smoothed_d  = div_result;
          last_out_d  = 1'b0;
          if (!last_q) begin
            state_d = ST_IDLE;
          end else if (flush_q != '0) begin
            state_d = ST_SUM;
          end else begin
            state_d = ST_ZERO;
          end
        end
      end

      ST_ZERO: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          smoothed_d  = '0;
          last_out_d  = (zcnt_q == WID_W'(1));
          zcnt_d      = zcnt_q - WID_W'(1);
          if (zcnt_q == WID_W'(1)) begin
            // The record is done: both delay lines count as empty again.
            pos_d   = '0;
            n2_d    = '0;
            state_d = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= tsf_pkg::CFG_RESET;
      last_q      <= 1'b0;
      pos_q       <= '0;
      n2_q        <= '0;
      hd1_q       <= '0;
      hd2_q       <= '0;
      rd_cnt_q    <= '0;
      pipe_v_q    <= 1'b0;
      flush_q     <= '0;
      idx_q       <= '0;
      zcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      last_q      <= last_d;
      pos_q       <= pos_d;
      n2_q        <= n2_d;
      hd1_q       <= hd1_d;
      hd2_q       <= hd2_d;
      rd_cnt_q    <= rd_cnt_d;
      pipe_v_q    <= issue;
      flush_q     <= flush_d;
      idx_q       <= idx_d;
      zcnt_q      <= zcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_i;
    end
    pipe_j_q   <= rd_cnt_q[PTR_W-1:0];
    acc1_q     <= acc1_d;
    acc2_q     <= acc2_d;
    smoothed_q <= smoothed_d;
    last_out_q <= last_out_d;
  end

  // The new word goes into the slot of the oldest one, which the walk never reads.
  always_ff @(posedge clk_i) begin
    if (mem1_we) begin
      sample_mem_q[hd1_m1] <= x_q;
    end
    rd1_q <= sample_mem_q[rd_addr1];
  end

  always_ff @(posedge clk_i) begin
    if (mem2_we) begin
      stage_mem_q[hd2_m1] <= sval;
    end
    rd2_q <= stage_mem_q[rd_addr2];
  end

  tsf_div #(
    .SUM_W (S2_W),
    .WID_W (WID_W)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .sum_i    (div_sum),
    .width_i  (w_eff),
    .done_o   (div_done),
    .result_o (div_result)
  );

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = smoothed_q;
  assign last_out_o  = last_out_q;

endmodule
